### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and rst_n in scope; checks are off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ursf_pkg.sv
// Package for the UART receive buffer with frame-start filter.
// Holds depth, widths, character codes, op codes and controller types; no dependencies.
`timescale 1ns / 1ps

package ursf_pkg;

    localparam int DEPTH  = 128;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W;
    localparam int FILL_W = 7;
    localparam int BYTE_W = 8;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEPTH - 1);

    localparam logic [BYTE_W-1:0] CH_AT      = 8'h40;
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

    typedef enum logic [1:0] {
        OP_RX    = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic exec;
        logic load;
    } dp_cmd_t;

endpackage

### hw/rtl/ursf_in_if.sv
// Request channel: valid/ready handshake carrying one event word.
// Depends on nothing.
`timescale 1ns / 1ps

interface ursf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic       framing_fault;
    logic       parity_fault;
    logic       overrun_error;
    logic       transmit_busy;

    modport source (
        output valid, op, rx_byte, framing_fault, parity_fault, overrun_error, transmit_busy,
        input  ready
    );
    modport sink (
        input  valid, op, rx_byte, framing_fault, parity_fault, overrun_error, transmit_busy,
        output ready
    );
    modport monitor (
        input valid, ready, op, rx_byte, framing_fault, parity_fault, overrun_error,
              transmit_busy
    );
endinterface

### hw/rtl/ursf_out_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on nothing.
`timescale 1ns / 1ps

interface ursf_out_if;
    logic       valid;
    logic       ready;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       byte_stored;
    logic [6:0] fill_count;
    logic       line_ready;
    logic       overflowed;

    modport source (
        output valid, read_valid, read_byte, byte_stored, fill_count, line_ready, overflowed,
        input  ready
    );
    modport sink (
        input  valid, read_valid, read_byte, byte_stored, fill_count, line_ready, overflowed,
        output ready
    );
    modport monitor (
        input valid, ready, read_valid, read_byte, byte_stored, fill_count, line_ready,
              overflowed
    );
endinterface

### hw/rtl/ursf_ctrl.sv
// Controller: sequences accept, execute and result load; owns the response valid.
// Depends on ursf_pkg.
`timescale 1ns / 1ps

module ursf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ursf_pkg::dp_cmd_t  cmd
);

    ursf_pkg::state_t state_reg;
    ursf_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ursf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd.exec   = 1'b0;
        cmd.load   = 1'b0;
        // Output slot is free if empty or being drained this cycle.
        slot_free  = !out_valid_reg || rsp_ready;
        case (state_reg)
            ursf_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ursf_pkg::ST_LOAD;
                end
            end
            ursf_pkg::ST_LOAD:
            begin
                // Hold the result until the output register can take it.
                if (slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ursf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ursf_pkg::ST_IDLE;
            end
        endcase

        if (cmd.load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

endmodule

### hw/rtl/ursf_dp.sv
// Datapath: byte ring memory, pointers, count, sticky flags and result register.
// Depends on ursf_pkg.
`timescale 1ns / 1ps

module ursf_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ursf_pkg::dp_cmd_t             cmd,
    input  logic [1:0]                    op,
    input  logic [ursf_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          framing_fault,
    input  logic                          parity_fault,
    input  logic                          overrun_error,
    input  logic                          transmit_busy,
    output logic                          read_valid,
    output logic [ursf_pkg::BYTE_W-1:0]   read_byte,
    output logic                          byte_stored,
    output logic [ursf_pkg::FILL_W-1:0]   fill_count,
    output logic                          line_ready,
    output logic                          overflowed
);

    logic [ursf_pkg::BYTE_W-1:0] mem [ursf_pkg::DEPTH];

    logic [ursf_pkg::PTR_W-1:0]  wp_reg, wp_next;
    logic [ursf_pkg::PTR_W-1:0]  rp_reg, rp_next;
    logic [ursf_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        line_reg, line_next;
    logic                        ovf_reg, ovf_next;

    logic [ursf_pkg::BYTE_W-1:0] rdata_reg;
    logic                        rvalid_reg;
    logic                        stored_reg;

    logic                        out_rvalid_reg;
    logic [ursf_pkg::BYTE_W-1:0] out_rbyte_reg;
    logic                        out_stored_reg;
    logic [ursf_pkg::FILL_W-1:0] out_fill_reg;
    logic                        out_line_reg;
    logic                        out_ovf_reg;

    ursf_pkg::op_t               op_code;
    logic                        is_start;
    logic                        drop;
    logic                        wr_en;
    logic                        rd_en;
    logic                        clr;

    always_comb
    begin
        op_code  = ursf_pkg::op_t'(op);
        is_start = (rx_byte == ursf_pkg::CH_AT) || (rx_byte == ursf_pkg::CH_DOLLAR) ||
                   (rx_byte == ursf_pkg::CH_PERCENT);
        drop     = ((count_reg == '0) && !is_start) || transmit_busy ||
                   framing_fault || parity_fault || overrun_error;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        clr      = 1'b0;
        if (cmd.exec)
        begin
            case (op_code)
                ursf_pkg::OP_RX:    wr_en = !drop;
                ursf_pkg::OP_READ:  rd_en = (count_reg != '0);
                ursf_pkg::OP_CLEAR: clr   = 1'b1;
                default:            clr   = 1'b0;
            endcase
        end

        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        line_next  = line_reg;
        ovf_next   = ovf_reg;

        if (wr_en)
        begin
            wp_next = (wp_reg == ursf_pkg::PTR_LAST) ? '0 : wp_reg + 1'b1;
            // Count falls back to zero at full depth and marks the overflow.
            if (count_reg == ursf_pkg::CNT_LAST)
            begin
                count_next = '0;
                ovf_next   = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
            if (rx_byte == ursf_pkg::CH_CR)
                line_next = 1'b1;
        end

        if (rd_en)
        begin
            rp_next    = (rp_reg == ursf_pkg::PTR_LAST) ? '0 : rp_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end

        if (clr)
        begin
            line_next = 1'b0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
            line_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
            line_reg  <= line_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= rx_byte;
        if (rd_en)
            rdata_reg <= mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rvalid_reg <= rd_en;
            stored_reg <= wr_en;
        end
        if (cmd.load)
        begin
            out_rvalid_reg <= rvalid_reg;
            out_rbyte_reg  <= rvalid_reg ? rdata_reg : '0;
            out_stored_reg <= stored_reg;
            out_fill_reg   <= ursf_pkg::FILL_W'(count_reg);
            out_line_reg   <= line_reg;
            out_ovf_reg    <= ovf_reg;
        end
    end

    assign read_valid  = out_rvalid_reg;
    assign read_byte   = out_rbyte_reg;
    assign byte_stored = out_stored_reg;
    assign fill_count  = out_fill_reg;
    assign line_ready  = out_line_reg;
    assign overflowed  = out_ovf_reg;

endmodule

### hw/rtl/uart_rx_fifo_start_filter_core.sv
// Channel  Dir  Word
// -------  ---  ----------------------------------------------------------------
// req      in   op, rx_byte, framing_fault, parity_fault, overrun_error, transmit_busy
// rsp      out  read_valid, read_byte, byte_stored, fill_count, line_ready, overflowed
//
// One event at a time: accepted in ST_IDLE (state update, memory write or read issued),
// result loaded into the output register from ST_LOAD once the output slot is free; the
// registered read port of the byte memory is why the load is a separate step.
// req.ready is low while an event is in flight; the next event is accepted while a result
// still waits in the output register; rsp stalls delay its load and the next accept.
// Asynchronous reset clears pointers, count and flags; no clearing pass on the memory.
//
// Top level: joins the controller and the datapath. Depends on ursf_pkg, ursf_in_if,
// ursf_out_if, ursf_ctrl and ursf_dp.
`timescale 1ns / 1ps

module uart_rx_fifo_start_filter_core (
    input  logic              clk,
    input  logic              rst_n,
    ursf_in_if.sink           req,
    ursf_out_if.source        rsp
);

    ursf_pkg::dp_cmd_t cmd;

    ursf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    ursf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (req.op),
        .rx_byte       (req.rx_byte),
        .framing_fault (req.framing_fault),
        .parity_fault  (req.parity_fault),
        .overrun_error (req.overrun_error),
        .transmit_busy (req.transmit_busy),
        .read_valid    (rsp.read_valid),
        .read_byte     (rsp.read_byte),
        .byte_stored   (rsp.byte_stored),
        .fill_count    (rsp.fill_count),
        .line_ready    (rsp.line_ready),
        .overflowed    (rsp.overflowed)
    );

endmodule

### hw/rtl/ursf_checker.sv
// Port-level checks for the UART receive buffer core, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ursf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       read_valid,
    input logic [7:0] read_byte,
    input logic       byte_stored
);

    // A stalled result word holds.
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped under stall")
    `ASSERT_NEXT(a_byte_hold, rsp_valid && !rsp_ready, $stable(read_byte), "read_byte moved in stall")

    // Only one event in flight: no accept right after an accept.
    `ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "req accepted twice in a row")

    // A word reports either a read or a store, never both.
    `ASSERT_SAME(a_read_or_store, rsp_valid, !(read_valid && byte_stored), "read and store in one word")

    // Byte field is zero unless a read found data.
    `ASSERT_SAME(a_byte_zero, rsp_valid && !read_valid, read_byte == 8'h00, "read_byte set without data")

endmodule

bind uart_rx_fifo_start_filter_core ursf_checker u_ursf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_valid  (rsp.read_valid),
    .read_byte   (rsp.read_byte),
    .byte_stored (rsp.byte_stored)
);

### test/tb.sv
// Self-checking bench for uart_rx_fifo_start_filter_core: drives receive, read and clear
// events with random stalls on both channels and checks every result word against a model.
// Depends on ursf_pkg, ursf_in_if, ursf_out_if and the core itself.
`timescale 1ns / 1ps

module tb;

    localparam int           ITEMS       = 1650;
    localparam int           HOLD_CYCLES = 80;
    localparam logic [1:0]   OP_SPARE    = 2'd3;

    localparam logic [3:0] FL_NONE    = 4'b0000;
    localparam logic [3:0] FL_FRAME   = 4'b1000;
    localparam logic [3:0] FL_PARITY  = 4'b0100;
    localparam logic [3:0] FL_OVERRUN = 4'b0010;
    localparam logic [3:0] FL_BUSY    = 4'b0001;
    localparam logic [3:0] FL_ALL     = 4'b1111;

    typedef struct packed {
        logic [1:0]                  op;
        logic [ursf_pkg::BYTE_W-1:0] rx_byte;
        logic                        framing_fault;
        logic                        parity_fault;
        logic                        overrun_error;
        logic                        transmit_busy;
    } rx_event_t;

    typedef struct packed {
        logic                        read_valid;
        logic [ursf_pkg::BYTE_W-1:0] read_byte;
        logic                        byte_stored;
        logic [ursf_pkg::FILL_W-1:0] fill_count;
        logic                        line_ready;
        logic                        overflowed;
    } rx_result_t;

    // Tracks the ring buffer and the expected result words in order.
    class rx_buffer_tracker;
        logic [ursf_pkg::BYTE_W-1:0] ring [ursf_pkg::DEPTH];
        int                wr_idx;
        int                rd_idx;
        int                held;
        bit                line_seen;
        bit                wrapped;
        rx_result_t        due_results[$];
        int                errors;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            wr_idx    = 0;
            rd_idx    = 0;
            held      = 0;
            line_seen = 0;
            wrapped   = 0;
            errors    = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_event(rx_event_t ev);
            rx_result_t r;
            bit         start_char;
            bit         drop;
            r = '0;
            case (ev.op)
                ursf_pkg::OP_RX:
                begin
                    start_char = (ev.rx_byte == ursf_pkg::CH_AT) ||
                                 (ev.rx_byte == ursf_pkg::CH_DOLLAR) ||
                                 (ev.rx_byte == ursf_pkg::CH_PERCENT);
                    drop = (held == 0 && !start_char) || ev.transmit_busy ||
                           ev.framing_fault || ev.parity_fault || ev.overrun_error;
                    if (!drop)
                    begin
                        ring[wr_idx] = ev.rx_byte;
                        if (ev.rx_byte == ursf_pkg::CH_CR)
                            line_seen = 1;
                        wr_idx = (wr_idx == ursf_pkg::DEPTH - 1) ? 0 : wr_idx + 1;
                        held++;
                        // Count wraps at full depth: buffer reads as empty again.
                        if (held >= ursf_pkg::DEPTH)
                        begin
                            held    = 0;
                            wrapped = 1;
                        end
                        r.byte_stored = 1'b1;
                    end
                end
                ursf_pkg::OP_READ:
                begin
                    if (held != 0)
                    begin
                        r.read_byte  = ring[rd_idx];
                        r.read_valid = 1'b1;
                        rd_idx = (rd_idx == ursf_pkg::DEPTH - 1) ? 0 : rd_idx + 1;
                        held--;
                    end
                end
                ursf_pkg::OP_CLEAR:
                begin
                    line_seen = 0;
                    wrapped   = 0;
                end
                default: ;
            endcase
            r.fill_count = ursf_pkg::FILL_W'(held);
            r.line_ready = line_seen;
            r.overflowed = wrapped;
            due_results.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(rx_result_t got);
            rx_result_t want;
            if (due_results.size() == 0)
            begin
                report("result word with none pending:", got, 0);
                return;
            end
            want = due_results.pop_front();
            if (got.read_valid !== want.read_valid)
                report("read_valid", got.read_valid, want.read_valid);
            if (got.read_byte !== want.read_byte)
                report("read_byte", got.read_byte, want.read_byte);
            if (got.byte_stored !== want.byte_stored)
                report("byte_stored", got.byte_stored, want.byte_stored);
            if (got.fill_count !== want.fill_count)
                report("fill_count", got.fill_count, want.fill_count);
            if (got.line_ready !== want.line_ready)
                report("line_ready", got.line_ready, want.line_ready);
            if (got.overflowed !== want.overflowed)
                report("overflowed", got.overflowed, want.overflowed);
        endtask
    endclass

    logic clk;
    logic rst_n;

    ursf_in_if  req_ch ();
    ursf_out_if rsp_ch ();

    uart_rx_fifo_start_filter_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rx_buffer_tracker tracker;
    int               issued;
    bit               send_quiet;
    bit               hold_req;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("uart_rx_fifo_start_filter_core: mismatch");
        $finish;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic rx_event_t mk_event(logic [1:0] op, logic [7:0] b, logic [3:0] flags);
        return {op, b, flags};
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] rand_flags();
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] pick_start();
        case ($urandom_range(0, 2))
            0:       return ursf_pkg::CH_AT;
            1:       return ursf_pkg::CH_DOLLAR;
            default: return ursf_pkg::CH_PERCENT;
        endcase
    endfunction

    // Mostly random data, with a carriage return or a start character now and then, and error flags on err_pct percent.
    function automatic rx_event_t frame_byte(int err_pct);
        logic [7:0] b;
        logic [3:0] fl;
        int         r;
        r = $urandom_range(0, 15);
        if (r == 0)
            b = ursf_pkg::CH_CR;
        else if (r == 1)
            b = pick_start();
        else
            b = rand_byte();
        fl = FL_NONE;
        if ($urandom_range(0, 99) < err_pct)
            fl = 4'($urandom_range(1, 15));
        return mk_event(ursf_pkg::OP_RX, b, fl);
    endfunction

    task automatic send_word(rx_event_t ev);
        int gap;
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.op            <= ev.op;
        req_ch.rx_byte       <= ev.rx_byte;
        req_ch.framing_fault <= ev.framing_fault;
        req_ch.parity_fault  <= ev.parity_fault;
        req_ch.overrun_error <= ev.overrun_error;
        req_ch.transmit_busy <= ev.transmit_busy;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        issued++;
        gap = pick_gap(send_quiet);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic idle_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Sample both channels at the rising edge; note the input word before checking.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (req_ch.valid && req_ch.ready)
                    tracker.note_event({req_ch.op, req_ch.rx_byte, req_ch.framing_fault,
                                        req_ch.parity_fault, req_ch.overrun_error,
                                        req_ch.transmit_busy});
                if (rsp_ch.valid && rsp_ch.ready)
                    tracker.check_result({rsp_ch.read_valid, rsp_ch.read_byte,
                                          rsp_ch.byte_stored, rsp_ch.fill_count,
                                          rsp_ch.line_ready, rsp_ch.overflowed});
            end
        end
    end

    // Result side: random stalls, calm stretches, and one long hold-off on request.
    initial
    begin
        int stall;
        int calm_left;
        rsp_ch.ready = 1'b0;
        calm_left    = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                stall    = HOLD_CYCLES;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                stall = 0;
            end
            else
            begin
                if ($urandom_range(0, 99) < 2)
                    calm_left = 60;
                stall = pick_gap(1'b0);
            end
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int  kind;
        int  len;
        bit  first;
        bit  hold_done;
        bit  pause_done;
        tracker              = new();
        issued               = 0;
        send_quiet           = 0;
        hold_req             = 0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.op            = ursf_pkg::OP_RX;
        req_ch.rx_byte       = '0;
        req_ch.framing_fault = 1'b0;
        req_ch.parity_fault  = 1'b0;
        req_ch.overrun_error = 1'b0;
        req_ch.transmit_busy = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-buffer cases, every filter, field extremes, all ops.
        send_word(mk_event(ursf_pkg::OP_READ, 8'h00, FL_NONE));
        send_word(mk_event(OP_SPARE, 8'hA5, FL_ALL));
        send_word(mk_event(ursf_pkg::OP_CLEAR, 8'h00, FL_NONE));
        send_word(mk_event(ursf_pkg::OP_RX, 8'h41, FL_NONE));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_CR, FL_NONE));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_AT, FL_FRAME));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_AT, FL_PARITY));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_AT, FL_OVERRUN));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_AT, FL_BUSY));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_AT, FL_NONE));
        send_word(mk_event(ursf_pkg::OP_RX, 8'h00, FL_NONE));
        send_word(mk_event(ursf_pkg::OP_RX, 8'hFF, FL_NONE));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_CR, FL_NONE));
        send_word(mk_event(ursf_pkg::OP_RX, 8'h78, FL_BUSY));
        send_word(mk_event(ursf_pkg::OP_RX, 8'h79, FL_ALL));
        send_word(mk_event(OP_SPARE, 8'hFF, FL_NONE));
        repeat (5) send_word(mk_event(ursf_pkg::OP_READ, 8'hFF, FL_ALL));
        send_word(mk_event(ursf_pkg::OP_CLEAR, 8'hFF, FL_ALL));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_DOLLAR, FL_NONE));
        send_word(mk_event(ursf_pkg::OP_RX, ursf_pkg::CH_PERCENT, FL_NONE));
        repeat (2) send_word(mk_event(ursf_pkg::OP_READ, 8'h00, FL_NONE));

        // Random: framed bursts, floods to the wrap point, noise and drains.
        first      = 1;
        hold_done  = 0;
        pause_done = 0;
        issued     = 0;
        while (issued < ITEMS)
        begin
            if (!hold_done && issued > 300)
            begin
                hold_req  = 1;
                hold_done = 1;
            end
            if (!pause_done && issued > 900)
            begin
                idle_until_drained();
                pause_done = 1;
            end
            kind       = first ? 0 : $urandom_range(0, 99);
            first      = 0;
            send_quiet = ($urandom_range(0, 99) < 15);
            if (kind < 8)
            begin
                send_word(mk_event(ursf_pkg::OP_RX, pick_start(), FL_NONE));
                repeat (130) send_word(frame_byte(0));
            end
            else if (kind < 60)
            begin
                len = $urandom_range(1, 20);
                send_word(mk_event(ursf_pkg::OP_RX, pick_start(), FL_NONE));
                repeat (len) send_word(frame_byte(10));
                repeat ($urandom_range(0, len + 4))
                    send_word(mk_event(ursf_pkg::OP_READ, rand_byte(), rand_flags()));
                if ($urandom_range(0, 3) == 0)
                    send_word(mk_event(ursf_pkg::OP_CLEAR, rand_byte(), rand_flags()));
            end
            else if (kind < 80)
            begin
                repeat ($urandom_range(1, 10))
                    send_word(mk_event(2'($urandom_range(0, 3)), rand_byte(), rand_flags()));
            end
            else
            begin
                repeat ($urandom_range(1, 40))
                    send_word(mk_event(ursf_pkg::OP_READ, rand_byte(), rand_flags()));
            end
        end

        idle_until_drained();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("uart_rx_fifo_start_filter_core: match");
        else
            $display("uart_rx_fifo_start_filter_core: mismatch");
        $finish;
    end

endmodule
